>>> src/assoc_cache_lru_writeback_unit_assert.svh
// Assertion macros for the cache tag store unit, clocked on clk and reset by rst_n.
`ifndef ASSOC_CACHE_LRU_WRITEBACK_UNIT_ASSERT_SVH
`define ASSOC_CACHE_LRU_WRITEBACK_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ACWB_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ACWB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/acwb_pkg.sv
// Shared types and constants for the fully associative cache tag store.
package acwb_pkg;

    localparam int MAX_ENTRIES_DEF = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE = 2'd1;

    localparam logic [CFG_DATA_W-1:0] OFFSET_RESET = 5'd5;
    localparam logic [CFG_DATA_W-1:0] BLOCKS_RESET = 5'd16;

    typedef enum logic [1:0] {
        S_IDLE,
        S_COMPARE,
        S_UPDATE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture an accepted word and form its tag
        logic compare;  // capture match and victim vectors
        logic update;   // commit ranks, tags, dirty marks and the result
    } ctrl_cmd_t;

endpackage

>>> src/acwb_ctrl.sv
// Controller state machine sequencing compare and update for each access.
module acwb_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output acwb_pkg::ctrl_cmd_t cmd
);
    import acwb_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        busy        = (state_reg == S_COMPARE);
        accept      = start && !busy;
        state_next  = state_reg;
        cmd.load    = accept;
        cmd.compare = 1'b0;
        cmd.update  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_COMPARE;
                end
            end
            S_COMPARE:
            begin
                cmd.compare = 1'b1;
                state_next  = S_UPDATE;
            end
            S_UPDATE:
            begin
                // The next word may enter while this one commits.
                cmd.update = 1'b1;
                state_next = accept ? S_COMPARE : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> src/acwb_dp.sv
// Datapath holding tags, LRU ranks, dirty marks, the writeback count and results.
module acwb_dp #(
    parameter int MAX_ENTRIES = acwb_pkg::MAX_ENTRIES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  acwb_pkg::ctrl_cmd_t             cmd,
    input  logic                            action,
    input  logic [31:0]                     address,
    input  logic                            cfg_we,
    input  logic [acwb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [acwb_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                            done,
    output logic                            was_hit,
    output logic [3:0]                      entry,
    output logic                            wrote_back,
    output logic [31:0]                     writeback_total
);
    import acwb_pkg::*;

    localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int CW     = (CNT_W > CFG_DATA_W) ? CNT_W : CFG_DATA_W;

    logic [CFG_DATA_W-1:0] offset_reg;
    logic [CFG_DATA_W-1:0] blocks_reg;

    logic [31:0]           tag_reg;
    logic                  write_reg;

    logic [31:0]           tags_reg   [MAX_ENTRIES];
    logic [31:0]           tags_next  [MAX_ENTRIES];
    logic [IDX_W-1:0]      rank_reg   [MAX_ENTRIES];
    logic [IDX_W-1:0]      rank_next  [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] dirty_reg;
    logic [MAX_ENTRIES-1:0] dirty_next;
    logic [31:0]           count_reg;
    logic [31:0]           count_next;

    logic [MAX_ENTRIES-1:0] match_reg;
    logic [MAX_ENTRIES-1:0] match_next;
    logic [MAX_ENTRIES-1:0] victim_reg;
    logic [MAX_ENTRIES-1:0] victim_next;

    logic                  done_reg;
    logic                  was_hit_reg;
    logic [3:0]            entry_reg;
    logic [3:0]            entry_next;
    logic                  wrote_back_reg;
    logic                  wrote_back_next;
    logic [31:0]           total_reg;

    logic [CW-1:0]         blk_ext;
    logic [CW-1:0]         n_cnt;
    logic [MAX_ENTRIES-1:0] in_use;

    logic                  hit;
    logic [IDX_W-1:0]      hit_pos;
    logic [IDX_W-1:0]      vic_pos;
    logic [IDX_W-1:0]      pos;
    logic [IDX_W-1:0]      old_rank;
    logic [IDX_W+3:0]      pos_ext;

    // Entries in use, with zero read as one and large counts saturated.
    always_comb
    begin
        blk_ext = CW'(blocks_reg);
        if (blk_ext == '0)
        begin
            n_cnt = CW'(1);
        end
        else if (blk_ext > CW'(MAX_ENTRIES))
        begin
            n_cnt = CW'(MAX_ENTRIES);
        end
        else
        begin
            n_cnt = blk_ext;
        end
        for (int k = 0; k < MAX_ENTRIES; k++)
        begin
            in_use[k] = (CW'(k) < n_cnt);
        end
    end

    // Parallel tag compare and victim test. An entry is the victim when every
    // lower entry in use ranks strictly below it and no higher one ranks above.
    always_comb
    begin
        for (int k = 0; k < MAX_ENTRIES; k++)
        begin
            match_next[k]  = in_use[k] && (tags_reg[k] == tag_reg);
            victim_next[k] = in_use[k];
            for (int j = 0; j < MAX_ENTRIES; j++)
            begin
                if (in_use[j] && (j < k) && !(rank_reg[j] < rank_reg[k]))
                begin
                    victim_next[k] = 1'b0;
                end
                if (in_use[j] && (j > k) && (rank_reg[j] > rank_reg[k]))
                begin
                    victim_next[k] = 1'b0;
                end
            end
        end
    end

    // Commit: choose the entry, promote it and age the younger entries.
    always_comb
    begin
        hit     = |match_reg;
        hit_pos = '0;
        vic_pos = '0;
        for (int k = MAX_ENTRIES - 1; k >= 0; k--)
        begin
            if (match_reg[k])
            begin
                hit_pos = IDX_W'(k);
            end
        end
        for (int k = 0; k < MAX_ENTRIES; k++)
        begin
            if (victim_reg[k])
            begin
                vic_pos = vic_pos | IDX_W'(k);
            end
        end
        pos      = hit ? hit_pos : vic_pos;
        old_rank = rank_reg[pos];

        for (int k = 0; k < MAX_ENTRIES; k++)
        begin
            tags_next[k] = tags_reg[k];
            rank_next[k] = rank_reg[k];
            if (in_use[k] && (rank_reg[k] < old_rank))
            begin
                rank_next[k] = rank_reg[k] + IDX_W'(1);
            end
        end
        rank_next[pos] = '0;
        dirty_next     = dirty_reg;

        wrote_back_next = !hit && dirty_reg[pos];
        if (hit)
        begin
            dirty_next[pos] = dirty_reg[pos] | write_reg;
        end
        else
        begin
            tags_next[pos]  = tag_reg;
            dirty_next[pos] = write_reg;
        end
        count_next = count_reg + {31'd0, wrote_back_next};
        pos_ext    = (IDX_W + 4)'(pos);
        entry_next = pos_ext[3:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= OFFSET_RESET;
            blocks_reg <= BLOCKS_RESET;
            for (int k = 0; k < MAX_ENTRIES; k++)
            begin
                tags_reg[k] <= '0;
                rank_reg[k] <= IDX_W'(k);
            end
            dirty_reg <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_OFFSET_BITS:   offset_reg <= cfg_data;
                    REG_BLOCKS_IN_USE: blocks_reg <= cfg_data;
                    default:           ;
                endcase
            end
            if (cmd.update)
            begin
                for (int k = 0; k < MAX_ENTRIES; k++)
                begin
                    tags_reg[k] <= tags_next[k];
                    rank_reg[k] <= rank_next[k];
                end
                dirty_reg <= dirty_next;
                count_reg <= count_next;
            end
            done_reg <= cmd.update;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            tag_reg   <= address >> offset_reg;
            write_reg <= action;
        end
        if (cmd.compare)
        begin
            match_reg  <= match_next;
            victim_reg <= victim_next;
        end
        if (cmd.update)
        begin
            was_hit_reg    <= hit;
            entry_reg      <= entry_next;
            wrote_back_reg <= wrote_back_next;
            total_reg      <= count_next;
        end
    end

    assign done            = done_reg;
    assign was_hit         = was_hit_reg;
    assign entry           = entry_reg;
    assign wrote_back      = wrote_back_reg;
    assign writeback_total = total_reg;

endmodule

>>> src/assoc_cache_lru_writeback_unit.sv
// Top level of the fully associative LRU write-back cache tag store.
//
//   channel   | handshake            | word
//   ----------+----------------------+-----------------------------------------
//   access    | start, busy          | action, address
//   result    | done (one cycle)     | was_hit, entry, wrote_back, writeback_total
//   config    | cfg_valid, cfg_ready | cfg_index, cfg_data
//
// An access word is accepted on a clock edge with start high and busy low.
// In the compare state the tag is checked against every entry in use and the
// LRU victim found; the update state commits ranks, tag and dirty mark, and a new
// word may be taken in the update state but not in compare. The result strobe done
// rises the cycle after commit and lasts one cycle; the receiver cannot stall it. Reset
// restores every entry to tag zero, clean, with rank equal to its index, and takes effect at once.
module assoc_cache_lru_writeback_unit #(
    parameter int MAX_ENTRIES = acwb_pkg::MAX_ENTRIES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            action,
    input  logic [31:0]                     address,
    output logic                            done,
    output logic                            was_hit,
    output logic [3:0]                      entry,
    output logic                            wrote_back,
    output logic [31:0]                     writeback_total,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [acwb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [acwb_pkg::CFG_DATA_W-1:0] cfg_data
);
    import acwb_pkg::*;

`include "assoc_cache_lru_writeback_unit_assert.svh"

    ctrl_cmd_t cmd;

    // The register file always accepts a write, so the port never back-pressures.
    assign cfg_ready = 1'b1;

    acwb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    acwb_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .action          (action),
        .address         (address),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .done            (done),
        .was_hit         (was_hit),
        .entry           (entry),
        .wrote_back      (wrote_back),
        .writeback_total (writeback_total)
    );

    // An accepted word always enters the compare cycle next.
    `ACWB_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not start compare")
    // A result strobe follows a commit cycle and nothing else.
    `ACWB_ASSERT_IMPL(a_done_after_update, done, $past(cmd.update), "result without commit")
    // A hit never evicts.
    `ACWB_ASSERT_IMPL(a_hit_no_wb, done && was_hit, !wrote_back, "writeback reported on a hit")
    // Each reported writeback advances the running total by exactly one.
    `ACWB_ASSERT_IMPL(a_wb_count, done && wrote_back,
        writeback_total == ($past(writeback_total) + 32'd1), "writeback total did not advance")

endmodule

>>> test/tb_assoc_cache_lru_writeback_unit.sv
// Self-checking testbench for the fully associative LRU write-back cache tag store.
module tb_assoc_cache_lru_writeback_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import acwb_pkg::*;

    localparam int ENTRIES = MAX_ENTRIES_DEF;

    // Register indexes with no register behind them. Writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    localparam int RANDOM_PHASES    = 12;
    localparam int WORDS_PER_PHASE  = 88;
    localparam int REPORT_LIMIT     = 10;

    // One predicted result word.
    typedef struct packed {
        logic        hit;
        logic [3:0]  slot;
        logic        evicted_dirty;
        logic [31:0] evict_total;
    } access_outcome_t;

    // The scoreboard carries its own copy of the tag store. Every accepted access
    // word is run through it at once, and the outcome waits in a queue until the
    // block presents its result word.
    class cache_tag_scoreboard;
        logic [31:0]      tag_store [ENTRIES];
        logic             dirty_bit [ENTRIES];
        logic [3:0]       lru_rank  [ENTRIES];
        logic [31:0]      evict_count;
        logic [4:0]       cfg_shift;
        logic [4:0]       cfg_blocks;
        access_outcome_t  outcome_q [$];
        int unsigned      mismatches;
        int unsigned      checked;
        int unsigned      hits_seen;

        function new();
            for (int k = 0; k < ENTRIES; k++)
            begin
                tag_store[k] = '0;
                dirty_bit[k] = 1'b0;
                lru_rank[k]  = 4'(k);
            end
            evict_count = '0;
            cfg_shift   = OFFSET_RESET;
            cfg_blocks  = BLOCKS_RESET;
            mismatches  = 0;
            checked     = 0;
            hits_seen   = 0;
        endfunction

        // Zero entries behaves as one, anything above the store size as the full store.
        function int unsigned used_entries();
            if (cfg_blocks == 0)
                return 1;
            if (cfg_blocks > ENTRIES)
                return ENTRIES;
            return cfg_blocks;
        endfunction

        function void note_reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_OFFSET_BITS)
                cfg_shift = val;
            else if (idx == REG_BLOCKS_IN_USE)
                cfg_blocks = val;
        endfunction

        // Move one entry to the front and age every entry in use that was younger.
        function void make_newest(int unsigned pos, int unsigned n);
            logic [3:0] old_rank;
            old_rank = lru_rank[pos];
            for (int unsigned k = 0; k < n; k++)
            begin
                if (lru_rank[k] < old_rank)
                    lru_rank[k] = lru_rank[k] + 4'd1;
            end
            lru_rank[pos] = 4'd0;
        endfunction

        function void note_access(logic is_write, logic [31:0] addr);
            int unsigned      n;
            int unsigned      pos;
            logic [31:0]      tag;
            logic [3:0]       oldest;
            bit               hit;
            bit               wb;
            access_outcome_t  o;
            n   = used_entries();
            tag = addr >> cfg_shift;
            hit = 1'b0;
            wb  = 1'b0;
            pos = 0;
            for (int unsigned k = 0; k < n; k++)
            begin
                if (!hit && tag_store[k] == tag)
                begin
                    hit = 1'b1;
                    pos = k;
                end
            end
            if (hit)
            begin
                make_newest(pos, n);
                if (is_write)
                    dirty_bit[pos] = 1'b1;
            end
            else
            begin
                // Strictly greater, so among tied ranks the lowest index is evicted.
                oldest = lru_rank[0];
                for (int unsigned k = 1; k < n; k++)
                begin
                    if (lru_rank[k] > oldest)
                    begin
                        oldest = lru_rank[k];
                        pos    = k;
                    end
                end
                make_newest(pos, n);
                tag_store[pos] = tag;
                if (dirty_bit[pos])
                begin
                    wb          = 1'b1;
                    evict_count = evict_count + 32'd1;
                end
                dirty_bit[pos] = is_write;
            end
            o.hit           = hit;
            o.slot          = 4'(pos);
            o.evicted_dirty = wb;
            o.evict_total   = evict_count;
            outcome_q.push_back(o);
        endfunction

        function void check_result(logic hit, logic [3:0] slot, logic wb, logic [31:0] total);
            access_outcome_t o;
            if (outcome_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("result word with no access pending:");
                    $display("  got hit=%0b entry=%0d wb=%0b total=%0d", hit, slot, wb, total);
                end
                return;
            end
            o = outcome_q.pop_front();
            checked++;
            if (o.hit)
                hits_seen++;
            if (hit !== o.hit || slot !== o.slot || wb !== o.evicted_dirty
                    || total !== o.evict_total)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("result %0d wrong:", checked);
                    $display("  expected hit=%0b entry=%0d wb=%0b total=%0d",
                             o.hit, o.slot, o.evicted_dirty, o.evict_total);
                    $display("  got      hit=%0b entry=%0d wb=%0b total=%0d",
                             hit, slot, wb, total);
                end
            end
        endfunction

        function int unsigned pending();
            return outcome_q.size();
        endfunction
    endclass

    // All block inputs hold known values from time zero.
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   start     = 1'b0;
    logic                   action    = 1'b0;
    logic [31:0]            address   = '0;
    logic                   cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   busy;
    logic                   done;
    logic                   was_hit;
    logic [3:0]             entry;
    logic                   wrote_back;
    logic [31:0]            writeback_total;
    logic                   cfg_ready;

    cache_tag_scoreboard    sb = new();
    int unsigned            words_sent = 0;
    int unsigned            settings_used = 0;

    assoc_cache_lru_writeback_unit #(
        .MAX_ENTRIES(ENTRIES)
    ) uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .action          (action),
        .address         (address),
        .done            (done),
        .was_hit         (was_hit),
        .entry           (entry),
        .wrote_back      (wrote_back),
        .writeback_total (writeback_total),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // The result strobe lasts a single cycle and cannot be held off, so every
    // edge with done high carries one result word that is checked right away.
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(was_hit, entry, wrote_back, writeback_total);
    end

    // Presents one access word and returns at the edge that accepts it. Start is
    // left high, so a following call keeps it high without a glitch.
    task automatic issue_access(input logic is_write, input logic [31:0] addr);
        start   <= 1'b1;
        action  <= is_write;
        address <= addr;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_access(is_write, addr);
        words_sent++;
    endtask

    // Idles the access side for a random number of cycles. Each cycle is idle
    // with the given chance in a hundred; junk on the payload must be ignored.
    task automatic sender_pause(input int unsigned pct);
        while ($urandom_range(99) < pct)
        begin
            start   <= 1'b0;
            action  <= 1'($urandom);
            address <= $urandom;
            @(posedge clk);
        end
    endtask

    // Drops start and waits until every predicted result word has come back,
    // then lets the block settle.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Presents one register word and returns at the edge that accepts it.
    // Valid stays high so back-to-back writes need no extra cycle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.note_reg_write(idx, val);
    endtask

    // Registers are only touched once the block has gone quiet. A spare index
    // may be written too, with random data, to show it has no effect.
    task automatic apply_settings(input logic [4:0] shift, input logic [4:0] blocks,
                                  input bit poke_spare);
        drain_results();
        write_reg(REG_OFFSET_BITS, shift);
        write_reg(REG_BLOCKS_IN_USE, blocks);
        if (poke_spare)
            write_reg(($urandom_range(1) != 0) ? REG_SPARE_3 : REG_SPARE_2,
                      CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Random traffic for one setting. Most addresses come from a small pool of
    // tags near the number of entries in use, so hits, evictions and dirty
    // writebacks all happen often; a tenth are fully random addresses.
    task automatic random_phase(input logic [4:0] shift, input logic [4:0] blocks,
                                input int unsigned idle_pct);
        logic [31:0]  tag_pool [24];
        int unsigned  used;
        int unsigned  pool_n;
        logic [31:0]  low_mask;
        logic [31:0]  addr;
        apply_settings(shift, blocks, $urandom_range(1) != 0);
        used     = (blocks == 0) ? 1 : ((blocks > ENTRIES) ? ENTRIES : blocks);
        pool_n   = $urandom_range(1, used + 6);
        low_mask = 32'((64'd1 << shift) - 64'd1);
        for (int k = 0; k < 24; k++)
            tag_pool[k] = $urandom >> shift;
        for (int i = 0; i < WORDS_PER_PHASE; i++)
        begin
            sender_pause(idle_pct);
            if ($urandom_range(9) == 0)
                addr = $urandom;
            else
                addr = (tag_pool[$urandom_range(pool_n - 1)] << shift) | ($urandom & low_mask);
            issue_access(1'($urandom), addr);
        end
    endtask

    initial
    begin
        // Reset is held low from time zero and released on a rising edge.
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, starting from the reset settings: a shift of five and
        // the full store. Every entry holds tag zero, so address zero hits entry 0.
        issue_access(1'b0, 32'h0000_0000);
        issue_access(1'b1, 32'h0000_001F);
        issue_access(1'b0, 32'hFFFF_FFFF);
        issue_access(1'b1, 32'h8000_0000);
        // A read hit on a dirty entry must leave the mark set.
        issue_access(1'b0, 32'h0000_0010);
        issue_access(1'b1, 32'hFFFF_FFE0);
        issue_access(1'b0, 32'h0000_0020);

        // No shift and a single entry: every miss evicts entry 0.
        apply_settings(5'd0, 5'd1, 1'b1);
        issue_access(1'b1, 32'h1234_5678);
        issue_access(1'b0, 32'h1234_5678);
        issue_access(1'b0, 32'hDEAD_BEEF);
        issue_access(1'b1, 32'h0000_0000);

        // The largest shift leaves one tag bit; zero entries act as one.
        apply_settings(5'd31, 5'd0, 1'b1);
        issue_access(1'b1, 32'h8000_0000);
        issue_access(1'b0, 32'h0000_0001);
        issue_access(1'b1, 32'hFFFF_FFFF);

        // Shift of sixteen and an oversized entry count that saturates.
        apply_settings(5'd16, 5'd31, 1'b1);
        issue_access(1'b1, 32'hABCD_0000);
        issue_access(1'b0, 32'hABCD_FFFF);
        issue_access(1'b0, 32'h0000_1234);
        issue_access(1'b1, 32'h5555_AAAA);

        // Shrinking and then growing the set in use leaves tied ranks behind,
        // so the lowest index among the oldest entries has to be chosen.
        apply_settings(5'd5, 5'd4, 1'b0);
        issue_access(1'b1, 32'h0100_0000);
        issue_access(1'b1, 32'h0200_0000);
        issue_access(1'b0, 32'h0300_0000);
        apply_settings(5'd5, 5'd17, 1'b0);
        issue_access(1'b0, 32'h0400_0000);
        issue_access(1'b1, 32'h0500_0000);
        issue_access(1'b0, 32'h0600_0000);

        // Random part. The first phases pin the extreme settings, the rest draw
        // them at random. Idle rates rotate among none, heavy and light.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            int unsigned idle_pct;
            logic [4:0]  shift;
            logic [4:0]  blocks;
            case (p % 3)
                0:       idle_pct = 0;
                1:       idle_pct = 68;
                default: idle_pct = 25;
            endcase
            case (p)
                0:       begin shift = 5'd5;  blocks = 5'd16; end
                1:       begin shift = 5'd0;  blocks = 5'd1;  end
                2:       begin shift = 5'd16; blocks = 5'd16; end
                3:       begin shift = 5'd31; blocks = 5'd2;  end
                4:       begin shift = 5'd0;  blocks = 5'd31; end
                default:
                begin
                    shift  = 5'($urandom_range(0, 20));
                    blocks = 5'($urandom_range(0, 31));
                end
            endcase
            random_phase(shift, blocks, idle_pct);
        end

        // Let every result word come back, then wait on in case the block
        // produces anything it should not.
        drain_results();
        repeat (8) @(posedge clk);

        $display("Sent %0d access words under %0d register settings; %0d results checked.",
                 words_sent, settings_used, sb.checked);
        $display("Predicted %0d hits and %0d dirty evictions; %0d mismatches.",
                 sb.hits_seen, sb.evict_count, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial
    begin
        #1_000_000;
        $display("Run stopped by the watchdog with %0d results outstanding.", sb.pending());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
